FILE: src/stereo_resampling_frame_fifo_defines.svh
// Assertion macros shared by the block's modules.
// Every use expects clk_i and rst_ni in scope.
`ifndef STEREO_RESAMPLING_FRAME_FIFO_DEFINES_SVH
`define STEREO_RESAMPLING_FRAME_FIFO_DEFINES_SVH
`ifndef SYNTHESIS
`define SRFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SRFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SRFF_ASSERT(lbl, prop, msg)
`define SRFF_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

FILE: src/srff_pkg.sv
package srff_pkg;

  // Ring and sample geometry.
  localparam int RingFrames    = 4096;
  localparam int RingAw        = $clog2(RingFrames);
  localparam int SampleW       = 16;
  localparam int FrameW        = 2 * SampleW;
  localparam int CountW        = 12;

  // Resampler fixed-point format.
  localparam int PhaseFracBits = 16;
  localparam int PhaseW        = 24;
  localparam int StepW         = 21;
  localparam int DiffW         = SampleW + 1;
  localparam int ProdW         = DiffW + PhaseFracBits + 1;
  localparam int NumW          = ProdW + 1;

  localparam logic [PhaseW-1:0] PhaseOne = PhaseW'(1) << PhaseFracBits;
  localparam logic [StepW-1:0]  StepOne  = StepW'(1) << PhaseFracBits;

  // Depth of the queue between front and back.
  localparam int QueueDepth = 2;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Item kinds as they arrive on the input port.
  typedef enum logic [1:0] {
    KindPush  = 2'd0,
    KindPull  = 2'd1,
    KindFlush = 2'd2,
    KindNop   = 2'd3
  } kind_e;

  // Operations after classification by the front.
  typedef enum logic [2:0] {
    OpPassPush,
    OpResPush,
    OpPull,
    OpFlush,
    OpNop
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic                     muted;
  } cmd_t;

endpackage

FILE: src/srff_ram.sv
module srff_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/srff_queue.sv
`include "stereo_resampling_frame_fifo_defines.svh"

module srff_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srff_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output srff_pkg::cmd_t cmd_o
);
  import srff_pkg::*;

  cmd_t                 slot_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 full;

  assign full    = (cnt_q == QueueCntW'(QueueDepth));
  assign full_o  = full;
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueueAw'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueueAw'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  `SRFF_ASSERT_IMP(a_no_push_when_full, push_i, !full, "queue written while full")
  `SRFF_ASSERT_IMP(a_no_pop_when_empty, pop_i, cnt_q != '0, "queue read while empty")

endmodule

FILE: src/srff_front.sv
module srff_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [srff_pkg::StepW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic signed [srff_pkg::SampleW-1:0] in_left_i,
  input  logic signed [srff_pkg::SampleW-1:0] in_right_i,
  input  logic                         muted_i,
  input  logic                         queue_full_i,
  output logic                         queue_push_o,
  output srff_pkg::cmd_t               cmd_o,
  output logic [srff_pkg::StepW-1:0]   rate_step_o
);
  import srff_pkg::*;

  logic [StepW-1:0] rate_step_q;
  logic             passthrough;
  kind_e            kind;

  // Rate step register; reset selects unity rate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_step_q <= StepOne;
    end else if (cfg_we_i) begin
      rate_step_q <= cfg_wdata_i;
    end
  end

  assign rate_step_o  = rate_step_q;
  assign passthrough  = (rate_step_q == '0) || (rate_step_q == StepOne);
  assign kind         = kind_e'(kind_i);
  assign in_ready_o   = !queue_full_i;
  assign queue_push_o = in_valid_i && !queue_full_i;

  // Classify the word into the operation the back end carries out.
  always_comb begin
    cmd_o.left  = in_left_i;
    cmd_o.right = in_right_i;
    cmd_o.muted = muted_i;
    unique case (kind)
      KindPush:  cmd_o.op = passthrough ? OpPassPush : OpResPush;
      KindPull:  cmd_o.op = OpPull;
      KindFlush: cmd_o.op = OpFlush;
      default:   cmd_o.op = OpNop;
    endcase
  end

endmodule

FILE: src/srff_back.sv
`include "stereo_resampling_frame_fifo_defines.svh"

module srff_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srff_pkg::StepW-1:0]          rate_step_i,
  input  logic                                cmd_valid_i,
  input  srff_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                accepted_o,
  output logic signed [srff_pkg::SampleW-1:0] out_left_o,
  output logic signed [srff_pkg::SampleW-1:0] out_right_o,
  output logic [srff_pkg::CountW-1:0]         pairs_written_o
);
  import srff_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StLoop,
    StWr,
    StRead
  } state_e;

  state_e                    state_q;
  cmd_t                      cmd_q;
  logic [RingAw-1:0]         wr_idx_q, rd_idx_q;
  logic [PhaseW-1:0]         phase_q;
  logic signed [SampleW-1:0] prev_l_q, prev_r_q;
  logic signed [ProdW-1:0]   prod_l_q, prod_r_q;
  logic [CountW-1:0]         cnt_q;
  logic                      out_valid_q, out_acc_q;
  logic signed [SampleW-1:0] out_l_q, out_r_q;
  logic [CountW-1:0]         out_cnt_q;

  logic                      full, empty, slot_free, pop;
  logic signed [DiffW-1:0]   diff_l, diff_r;
  logic signed [ProdW-1:0]   frac_s;
  logic signed [SampleW-1:0] lerp_l, lerp_r;
  logic [PhaseW:0]           phase_sum;
  logic [PhaseW-1:0]         phase_add, phase_dec;
  logic                      ram_we, ram_re;
  logic [FrameW-1:0]         ram_wdata, ram_rdata;

  function automatic logic [RingAw-1:0] ring_next(input logic [RingAw-1:0] i);
    return (i == RingAw'(RingFrames - 1)) ? '0 : i + 1'b1;
  endfunction

  // Finish the interpolation: add the scaled previous sample and truncate
  // toward zero on the way out of the fixed-point format.
  function automatic logic signed [SampleW-1:0] lerp_fin(
    input logic signed [SampleW-1:0] a,
    input logic signed [ProdW-1:0]   prod
  );
    logic signed [NumW-1:0] num;
    logic signed [NumW-1:0] adj;
    logic signed [NumW-1:0] quo;
    num = (NumW'(a) <<< PhaseFracBits) + NumW'(prod);
    adj = num[NumW-1] ? num + NumW'((1 << PhaseFracBits) - 1) : num;
    quo = adj >>> PhaseFracBits;
    return quo[SampleW-1:0];
  endfunction

  assign full      = (ring_next(wr_idx_q) == rd_idx_q);
  assign empty     = (wr_idx_q == rd_idx_q);
  assign slot_free = !out_valid_q || out_ready_i;
  assign pop       = (state_q == StIdle) && cmd_valid_i && slot_free;
  assign cmd_pop_o = pop;

  // Difference operands for the interpolation multipliers.
  assign diff_l = DiffW'(cmd_q.left) - DiffW'(prev_l_q);
  assign diff_r = DiffW'(cmd_q.right) - DiffW'(prev_r_q);
  assign frac_s = ProdW'($signed({1'b0, phase_q[PhaseFracBits-1:0]}));
  assign lerp_l = lerp_fin(prev_l_q, prod_l_q);
  assign lerp_r = lerp_fin(prev_r_q, prod_r_q);

  // Phase advance saturates at all ones; the end-of-word step saturates at zero.
  assign phase_sum = {1'b0, phase_q} + (PhaseW + 1)'(rate_step_i);
  assign phase_add = phase_sum[PhaseW] ? '1 : phase_sum[PhaseW-1:0];
  assign phase_dec = (phase_q < PhaseOne) ? '0 : phase_q - PhaseOne;

  // Ring access.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = {cmd_q.right, cmd_q.left};
    if (state_q == StExec && cmd_q.op == OpPassPush && !full) begin
      ram_we = 1'b1;
    end
    if (state_q == StWr && !full) begin
      ram_we    = 1'b1;
      ram_wdata = {lerp_r, lerp_l};
    end
    if (state_q == StExec && cmd_q.op == OpPull && !cmd_q.muted && !empty) begin
      ram_re = 1'b1;
    end
  end

  srff_ram #(
    .Width (FrameW),
    .Depth (RingFrames)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer: state, resampler registers and the output word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= '0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      phase_q     <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      prod_l_q    <= '0;
      prod_r_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_acc_q   <= 1'b0;
      out_l_q     <= '0;
      out_r_q     <= '0;
      out_cnt_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (pop) begin
            cmd_q   <= cmd_i;
            state_q <= StExec;
          end
        end
        StExec: begin
          out_acc_q <= 1'b0;
          out_l_q   <= '0;
          out_r_q   <= '0;
          out_cnt_q <= '0;
          cnt_q     <= '0;
          state_q   <= StIdle;
          unique case (cmd_q.op)
            OpPassPush: begin
              out_valid_q <= 1'b1;
              if (!full) begin
                wr_idx_q  <= ring_next(wr_idx_q);
                out_acc_q <= 1'b1;
                out_cnt_q <= CountW'(1);
              end
            end
            OpResPush: begin
              state_q <= StLoop;
            end
            OpPull: begin
              if (!cmd_q.muted && !empty) begin
                rd_idx_q <= ring_next(rd_idx_q);
                state_q  <= StRead;
              end else begin
                out_valid_q <= 1'b1;
              end
            end
            OpFlush: begin
              wr_idx_q    <= '0;
              rd_idx_q    <= '0;
              phase_q     <= '0;
              prev_l_q    <= '0;
              prev_r_q    <= '0;
              out_acc_q   <= 1'b1;
              out_valid_q <= 1'b1;
            end
            default: begin
              out_valid_q <= 1'b1;
            end
          endcase
        end
        StLoop: begin
          if (phase_q < PhaseOne) begin
            prod_l_q <= ProdW'(diff_l) * frac_s;
            prod_r_q <= ProdW'(diff_r) * frac_s;
            state_q  <= StWr;
          end else begin
            phase_q     <= phase_dec;
            prev_l_q    <= cmd_q.left;
            prev_r_q    <= cmd_q.right;
            out_acc_q   <= 1'b1;
            out_cnt_q   <= cnt_q;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        StWr: begin
          if (full) begin
            // Ring full stops the loop; the phase is below one here.
            phase_q     <= phase_dec;
            prev_l_q    <= cmd_q.left;
            prev_r_q    <= cmd_q.right;
            out_acc_q   <= 1'b0;
            out_cnt_q   <= cnt_q;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end else begin
            wr_idx_q <= ring_next(wr_idx_q);
            cnt_q    <= cnt_q + 1'b1;
            phase_q  <= phase_add;
            state_q  <= StLoop;
          end
        end
        StRead: begin
          out_acc_q   <= 1'b1;
          out_l_q     <= ram_rdata[SampleW-1:0];
          out_r_q     <= ram_rdata[FrameW-1:SampleW];
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
      // A rate change restarts the resampler phase.
      if (cfg_we_i) begin
        phase_q <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_acc_q;
  assign out_left_o      = out_l_q;
  assign out_right_o     = out_r_q;
  assign pairs_written_o = out_cnt_q;

  `SRFF_ASSERT_IMP(a_ring_write_not_full, ram_we, !full, "ring written while full")
  `SRFF_ASSERT_IMP(a_interp_phase_below_one, state_q == StWr, phase_q < PhaseOne,
                   "interpolation phase out of range")
  `SRFF_ASSERT(a_read_gives_word, (state_q == StRead) |=> (out_valid_q && out_acc_q),
               "pulled frame not delivered")
  `SRFF_ASSERT_IMP(a_count_only_on_push, out_valid_q && out_cnt_q != '0,
                   cmd_q.op == OpPassPush || cmd_q.op == OpResPush,
                   "pair count on a word that is not a push")

endmodule

FILE: src/stereo_resampling_frame_fifo.sv
// Flow: an accepted word passes the front queue, then the back-end sequencer's idle and exec
// states; a pull that reads the ring adds the read state, and a resampled push alternates between
// the loop and write states, one write per stored pair. The sequencer takes no new word until it
// has finished the last one and its output slot is free; the front queue holds 2 words.
// Reset (asynchronous, active low) empties the ring and queue, clears phase and
// previous pair, and sets the rate step to unity; no clearing pass is needed.
module stereo_resampling_frame_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srff_pkg::StepW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          kind_i,
  input  logic signed [srff_pkg::SampleW-1:0] in_left_i,
  input  logic signed [srff_pkg::SampleW-1:0] in_right_i,
  input  logic                                muted_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                accepted_o,
  output logic signed [srff_pkg::SampleW-1:0] out_left_o,
  output logic signed [srff_pkg::SampleW-1:0] out_right_o,
  output logic [srff_pkg::CountW-1:0]         pairs_written_o
);
  import srff_pkg::*;

  cmd_t             front_cmd, queue_cmd;
  logic             queue_push, queue_full, queue_valid, queue_pop;
  logic [StepW-1:0] rate_step;

  // Front end: configuration register and word classification.
  srff_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .in_left_i    (in_left_i),
    .in_right_i   (in_right_i),
    .muted_i      (muted_i),
    .queue_full_i (queue_full),
    .queue_push_o (queue_push),
    .cmd_o        (front_cmd),
    .rate_step_o  (rate_step)
  );

  // Decoupling queue between the two halves.
  srff_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // Back end: resampler, ring and output register.
  srff_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .rate_step_i     (rate_step),
    .cmd_valid_i     (queue_valid),
    .cmd_i           (queue_cmd),
    .cmd_pop_o       (queue_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .out_left_o      (out_left_o),
    .out_right_o     (out_right_o),
    .pairs_written_o (pairs_written_o)
  );

endmodule

FILE: bench/tb_stereo_resampling_frame_fifo.sv
import srff_pkg::*;

// One result word as the block should present it.
typedef struct {
  logic                      acc;
  logic signed [SampleW-1:0] left;
  logic signed [SampleW-1:0] right;
  logic [CountW-1:0]         pairs;
} frame_result_t;

// Tracks the ring, the resampler phase and the previous pair, and keeps the
// results still owed by the block in arrival order.
class frame_fifo_scoreboard;
  logic [FrameW-1:0]         ring [RingFrames];
  logic [RingAw-1:0]         wr_ptr;
  logic [RingAw-1:0]         rd_ptr;
  logic [PhaseW-1:0]         phase;
  logic signed [SampleW-1:0] prev_left;
  logic signed [SampleW-1:0] prev_right;
  logic [StepW-1:0]          step;
  frame_result_t             due_q[$];
  int unsigned               n_errors;

  function new();
    wr_ptr     = '0;
    rd_ptr     = '0;
    phase      = '0;
    prev_left  = '0;
    prev_right = '0;
    step       = StepOne;
    n_errors   = 0;
  endfunction

  // A register write also restarts the phase.
  function void write_step(logic [StepW-1:0] value);
    step  = value;
    phase = '0;
  endfunction

  // Stores one frame unless the ring is full.
  function bit put_frame(logic signed [SampleW-1:0] l, logic signed [SampleW-1:0] r);
    logic [RingAw-1:0] nxt;
    nxt = wr_ptr + 1'b1;
    if (nxt == rd_ptr) return 1'b0;
    ring[wr_ptr] = {r, l};
    wr_ptr = nxt;
    return 1'b1;
  endfunction

  // Exact interpolation at the current phase, truncated toward zero once.
  function logic signed [SampleW-1:0] blend(logic signed [SampleW-1:0] a,
                                            logic signed [SampleW-1:0] b);
    longint num;
    num = longint'(a) * (longint'(1) << PhaseFracBits)
        + (longint'(b) - longint'(a)) * longint'(phase);
    return SampleW'(num / (longint'(1) << PhaseFracBits));
  endfunction

  // Works out the result of an accepted input word and queues it.
  function void note_word(kind_e kind, logic signed [SampleW-1:0] l,
                          logic signed [SampleW-1:0] r, logic muted);
    frame_result_t res;
    logic [PhaseW:0] sum;
    int unsigned     guard;
    int unsigned     written;
    bit              ok;
    res.acc   = 1'b0;
    res.left  = '0;
    res.right = '0;
    res.pairs = '0;
    written   = 0;
    case (kind)
      KindPush: begin
        if (step == '0 || step == StepOne) begin
          if (put_frame(l, r)) begin
            res.acc = 1'b1;
            written = 1;
          end
        end else begin
          ok    = 1'b1;
          guard = 0;
          while (phase < PhaseOne && guard < RingFrames) begin
            guard++;
            if (!put_frame(blend(prev_left, l), blend(prev_right, r))) begin
              ok = 1'b0;
              break;
            end
            written++;
            sum   = phase + step;
            phase = (sum > {1'b0, {PhaseW{1'b1}}}) ? '1 : sum[PhaseW-1:0];
          end
          // Take one off the phase, stopping at zero.
          if (phase < PhaseOne) phase = '0;
          else phase = phase - PhaseOne;
          prev_left  = l;
          prev_right = r;
          res.acc    = ok;
        end
        res.pairs = CountW'(written);
      end
      KindPull: begin
        if (!muted && rd_ptr != wr_ptr) begin
          res.left  = ring[rd_ptr][SampleW-1:0];
          res.right = ring[rd_ptr][FrameW-1:SampleW];
          rd_ptr    = rd_ptr + 1'b1;
          res.acc   = 1'b1;
        end
      end
      KindFlush: begin
        wr_ptr     = '0;
        rd_ptr     = '0;
        phase      = '0;
        prev_left  = '0;
        prev_right = '0;
        res.acc    = 1'b1;
      end
      default: begin
      end
    endcase
    due_q.push_back(res);
  endfunction

  task report(string what);
    n_errors++;
    if (n_errors <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Compares one accepted result word with the oldest one owed.
  task check_result(logic acc, logic signed [SampleW-1:0] l,
                    logic signed [SampleW-1:0] r, logic [CountW-1:0] pairs);
    frame_result_t want;
    if (due_q.size() == 0) begin
      report($sformatf("unexpected result acc=%0b left=%0d right=%0d pairs=%0d",
                       acc, l, r, pairs));
      return;
    end
    want = due_q.pop_front();
    if (acc !== want.acc || l !== want.left || r !== want.right || pairs !== want.pairs)
      report($sformatf("acc %0b/%0b left %0d/%0d right %0d/%0d pairs %0d/%0d (got/want)",
                       acc, want.acc, l, want.left, r, want.right, pairs, want.pairs));
  endtask
endclass

module tb_stereo_resampling_frame_fifo;

  localparam int unsigned      QuietLimit = 50000;
  localparam int unsigned      WordTarget = 1450;
  localparam logic [StepW-1:0] StepMax    = StepW'(1048576);

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [StepW-1:0]          cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic [1:0]                kind_i      = KindNop;
  logic signed [SampleW-1:0] in_left_i   = '0;
  logic signed [SampleW-1:0] in_right_i  = '0;
  logic                      muted_i     = 1'b0;
  logic                      out_ready_i = 1'b0;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic                      accepted_o;
  logic signed [SampleW-1:0] out_left_o;
  logic signed [SampleW-1:0] out_right_o;
  logic [CountW-1:0]         pairs_written_o;

  bit                        idling = 1'b1;
  int unsigned               words_sent = 0;
  frame_fifo_scoreboard      sb;

  stereo_resampling_frame_fifo u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .in_left_i       (in_left_i),
    .in_right_i      (in_right_i),
    .muted_i         (muted_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .out_left_o      (out_left_o),
    .out_right_o     (out_right_o),
    .pairs_written_o (pairs_written_o)
  );

  always #6 clk_i = ~clk_i;

  // Offers one input word, after an occasional idle gap, and waits until it
  // is taken. Valid is left high so that a following word can go straight on.
  task automatic send_word(kind_e kind, logic signed [SampleW-1:0] l,
                           logic signed [SampleW-1:0] r, logic muted);
    int unsigned gap;
    gap = 0;
    while (idling && $urandom_range(0, 99) < 8) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    in_left_i  <= l;
    in_right_i <= r;
    muted_i    <= muted;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(kind, l, r, muted);
    words_sent++;
  endtask

  // Writes the rate step once the block has drained and settled.
  task automatic write_rate_step(logic [StepW-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_step(value);
  endtask

  // Samples lean towards the extremes now and then.
  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3:       return '1;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // Mostly moderate ratios; very small steps, which can fill the ring from one
  // push, are kept rare.
  function automatic logic [StepW-1:0] pick_rate_step();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 25) return StepOne;
    if (roll < 32) return StepMax;
    if (roll < 35) return StepW'($urandom_range(1, 64));
    if (roll < 50) return StepW'($urandom_range(200, 4000));
    if (roll < 85) return StepW'($urandom_range(16384, 200000));
    return StepW'($urandom_range(1, 1048576));
  endfunction

  task automatic send_random_word(int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      send_word(KindPush, pick_sample(), pick_sample(), 1'($urandom));
    else if (roll < 92)
      send_word(KindPull, pick_sample(), pick_sample(), $urandom_range(0, 99) < 15);
    else if (roll < 95)
      send_word(KindFlush, pick_sample(), pick_sample(), 1'($urandom));
    else
      send_word(KindNop, pick_sample(), pick_sample(), 1'($urandom));
  endtask

  // Directed words: extremes, underrun, mute, flush, every kind of rate step
  // and both ways the ring can turn a push away.
  task automatic run_directed();
    send_word(KindPull, '0, '0, 1'b0);
    send_word(KindPush, 16'sh8000, 16'sh7FFF, 1'b0);
    send_word(KindPush, 16'sh7FFF, 16'sh8000, 1'b1);
    send_word(KindPush, '1, '0, 1'b0);
    send_word(KindPull, '0, '0, 1'b1);
    repeat (4) send_word(KindPull, '0, '0, 1'b0);
    send_word(KindNop, '1, '1, 1'b1);
    send_word(KindFlush, '0, '0, 1'b0);
    // Twofold upsampling; the half-way value must round toward zero.
    write_rate_step(StepW'(32768));
    send_word(KindPush, -16'sd32767, 16'sd32767, 1'b0);
    send_word(KindPush, 16'sh7FFF, 16'sh8000, 1'b0);
    repeat (2) send_word(KindPull, '0, '0, 1'b0);
    send_word(KindFlush, '0, '0, 1'b0);
    write_rate_step(StepW'(98304));
    send_word(KindPush, 16'sd1234, -16'sd4321, 1'b0);
    send_word(KindPush, -16'sd32000, 16'sd31000, 1'b0);
    send_word(KindPush, 16'sd5, -16'sd5, 1'b0);
    send_word(KindPull, '0, '0, 1'b0);
    write_rate_step(StepMax);
    send_word(KindPush, 16'sh8000, 16'sh7FFF, 1'b0);
    send_word(KindPush, 16'sh7FFF, 16'sh8000, 1'b0);
    write_rate_step('0);
    send_word(KindPush, 16'sd77, -16'sd77, 1'b0);
    send_word(KindPull, '0, '0, 1'b0);
    // The smallest step fills the whole ring from one push, then turns the
    // next one away.
    write_rate_step(StepW'(1));
    send_word(KindPush, 16'sd1000, -16'sd1000, 1'b0);
    send_word(KindPush, -16'sd1000, 16'sd1000, 1'b0);
    // A full ring drops a passthrough pair.
    write_rate_step(StepOne);
    send_word(KindPush, 16'sd42, 16'sd43, 1'b0);
    send_word(KindPull, '0, '0, 1'b0);
    send_word(KindFlush, '0, '0, 1'b0);
  endtask

  // Result side: check every accepted word and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(accepted_o, out_left_o, out_right_o, pairs_written_o);
      out_ready_i <= !(idling && $urandom_range(0, 99) < 8);
    end
  end

  // Watchdog: ends the run if neither side moves a word for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus: reset, the directed words, then random phases each with its
  // own rate step and mix of kinds.
  initial begin
    int unsigned n_phase;
    int unsigned phase_len;
    int unsigned push_pct;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    n_phase = 0;
    while (words_sent < WordTarget) begin
      // One phase runs with neither side ever idling.
      idling = (n_phase != 2);
      write_rate_step(pick_rate_step());
      phase_len = (n_phase == 2) ? 200 : $urandom_range(40, 120);
      push_pct  = $urandom_range(30, 70);
      repeat (phase_len) send_random_word(push_pct);
      n_phase++;
    end
    in_valid_i <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.due_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/srff_pkg.sv
src/srff_ram.sv
src/srff_queue.sv
src/srff_front.sv
src/srff_back.sv
src/stereo_resampling_frame_fifo.sv
bench/tb_stereo_resampling_frame_fifo.sv
